// ===== hw/rtl/bkrd_pkg.sv =====
package bkrd_pkg;

    localparam int SLOT_COUNT        = 6;
    localparam int EVENT_COUNT       = 2 * SLOT_COUNT;
    localparam int EV_IDX_W          = $clog2(EVENT_COUNT);
    localparam int SLOT_IDX_W        = $clog2(SLOT_COUNT);
    localparam int BOOT_REPORT_BYTES = 8;
    localparam int FIFO_DEPTH        = 2;
    localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W        = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] MIN_VALID_CODE_RESET = 8'd3;

    // register indexes
    localparam logic REG_MIN_VALID_CODE = 1'b0;

    // one classified report: bit 2*i is the release of old slot i,
    // bit 2*i+1 is the press of new slot i
    typedef struct packed {
        logic [EVENT_COUNT-1:0]           mask;
        logic [SLOT_COUNT-1:0][7:0]       old_keys;
        logic [SLOT_COUNT-1:0][7:0]       new_keys;
        logic [7:0]                       modifier;
    } bkrd_entry_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } bkrd_fifo_status_t;

endpackage

// ===== hw/rtl/boot_keyboard_report_diff.sv =====
// channel   | direction | transaction                                   | handshake
// s_ report | in        | length, modifier byte, six key codes          | s_valid / s_ready
// m_ event  | out       | code, modifier, press flag, last-of-report    | m_valid / m_ready
// apb       | in        | min_valid_code at byte address 0              | psel/penable, pready=1
//
// A report is classified in the cycle it is accepted (72 parallel slot compares);
// a report yields 0 to 12 events, emitted one per cycle by the back sequencer while m_ready is high.
// Throughput is set by the single output register; the next queued report loads with the last event.
// Two classified reports queue between front and back; s_ready drops only when it is full.
// Synchronous active-low reset clears the stored keys, queue and output; min_valid_code to 3.
module boot_keyboard_report_diff
    import bkrd_pkg::*;
#(
    parameter int KEY_SLOTS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [6:0]  s_report_len,
    input  logic [7:0]  s_modifier_bits,
    input  logic [7:0]  s_key_0,
    input  logic [7:0]  s_key_1,
    input  logic [7:0]  s_key_2,
    input  logic [7:0]  s_key_3,
    input  logic [7:0]  s_key_4,
    input  logic [7:0]  s_key_5,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_event_code,
    output logic [7:0]  m_event_modifier,
    output logic        m_is_press,
    output logic        m_last_event,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]        min_valid_code_reg, min_valid_code_next;
    logic              cfg_write;
    logic              accept;
    logic              push;
    logic              pop;
    bkrd_entry_t       push_data;
    bkrd_entry_t       head_data;
    bkrd_fifo_status_t fifo_status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        min_valid_code_next = min_valid_code_reg;
        if (cfg_write && (paddr[2] == REG_MIN_VALID_CODE)) begin
            min_valid_code_next = pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_valid_code_reg <= MIN_VALID_CODE_RESET;
        end else begin
            min_valid_code_reg <= min_valid_code_next;
        end
    end

    assign prdata = (paddr[2] == REG_MIN_VALID_CODE) ? {24'd0, min_valid_code_reg} : 32'd0;

    assign s_ready = !fifo_status.full;
    assign accept  = s_valid && s_ready;

    bkrd_front #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .rpt_len        (s_report_len),
        .modifier_bits  (s_modifier_bits),
        .keys           ({s_key_5, s_key_4, s_key_3, s_key_2, s_key_1, s_key_0}),
        .min_valid_code (min_valid_code_reg),
        .push           (push),
        .push_data      (push_data)
    );

    bkrd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .status    (fifo_status)
    );

    bkrd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_data        (head_data),
        .head_valid       (fifo_status.not_empty),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_code     (m_event_code),
        .m_event_modifier (m_event_modifier),
        .m_is_press       (m_is_press),
        .m_last_event     (m_last_event)
    );

endmodule

// ===== hw/rtl/bkrd_front.sv =====
module bkrd_front
    import bkrd_pkg::*;
#(
    parameter int KEY_SLOTS = 6
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     accept,
    input  logic [6:0]               rpt_len,
    input  logic [7:0]               modifier_bits,
    input  logic [SLOT_COUNT-1:0][7:0] keys,
    input  logic [7:0]               min_valid_code,
    output logic                     push,
    output bkrd_entry_t              push_data
);

    logic [SLOT_COUNT-1:0][7:0] held_keys_reg;
    logic [SLOT_COUNT-1:0][7:0] held_keys_next;
    logic                       full_report;
    logic [EVENT_COUNT-1:0]     mask;
    logic                       old_found;
    logic                       new_found;

    assign full_report = (rpt_len >= 7'(BOOT_REPORT_BYTES));

    always_comb begin
        mask = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            old_found = 1'b0;
            new_found = 1'b0;
            for (int j = 0; j < SLOT_COUNT; j++) begin
                if (j < KEY_SLOTS) begin
                    if (keys[j] == held_keys_reg[i]) old_found = 1'b1;
                    if (held_keys_reg[j] == keys[i]) new_found = 1'b1;
                end
            end
            if (i < KEY_SLOTS) begin
                mask[2*i]   = (held_keys_reg[i] > min_valid_code) && !old_found;
                mask[2*i+1] = (keys[i] > min_valid_code) && !new_found;
            end
        end
    end

    assign push_data.mask     = mask;
    assign push_data.old_keys = held_keys_reg;
    assign push_data.new_keys = keys;
    assign push_data.modifier = modifier_bits;
    assign push = accept && full_report && (mask != '0);

    always_comb begin
        held_keys_next = held_keys_reg;
        if (accept && full_report) begin
            held_keys_next = keys;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_keys_reg <= '0;
        end else begin
            held_keys_reg <= held_keys_next;
        end
    end

endmodule

// ===== hw/rtl/bkrd_fifo.sv =====
module bkrd_fifo
    import bkrd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  bkrd_entry_t       push_data,
    input  logic              pop,
    output bkrd_entry_t       head_data,
    output bkrd_fifo_status_t status
);

    bkrd_entry_t               entries_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]     count_reg, count_next;

    assign status.full      = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign head_data        = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/bkrd_back.sv =====
module bkrd_back
    import bkrd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  bkrd_entry_t       head_data,
    input  logic              head_valid,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_event_code,
    output logic [7:0]        m_event_modifier,
    output logic              m_is_press,
    output logic              m_last_event
);

    logic                   cur_valid_reg, cur_valid_next;
    bkrd_entry_t            cur_reg, cur_next;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             code_reg, code_next;
    logic [7:0]             mod_reg, mod_next;
    logic                   press_reg, press_next;
    logic                   last_reg, last_next;

    logic                   advance;
    logic [EV_IDX_W-1:0]    ev_idx;
    logic [SLOT_IDX_W-1:0]  slot;
    logic [EVENT_COUNT-1:0] remaining;

    assign advance = !out_valid_reg || m_ready;

    // lowest pending event first
    always_comb begin
        ev_idx = '0;
        for (int j = EVENT_COUNT - 1; j >= 0; j--) begin
            if (cur_reg.mask[j]) ev_idx = EV_IDX_W'(j);
        end
    end

    assign slot      = ev_idx[EV_IDX_W-1:1];
    assign remaining = cur_reg.mask & ~(EVENT_COUNT'(1) << ev_idx);

    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        code_next      = code_reg;
        mod_next       = mod_reg;
        press_next     = press_reg;
        last_next      = last_reg;
        pop            = 1'b0;

        if (advance) begin
            out_valid_next = 1'b0;
        end

        if (cur_valid_reg && advance) begin
            out_valid_next = 1'b1;
            press_next     = ev_idx[0];
            code_next      = ev_idx[0] ? cur_reg.new_keys[slot] : cur_reg.old_keys[slot];
            mod_next       = ev_idx[0] ? cur_reg.modifier : 8'd0;
            last_next      = (remaining == '0);
            cur_next.mask  = remaining;
            if (remaining == '0) begin
                // chain straight into the next report
                cur_valid_next = head_valid;
                pop            = head_valid;
                if (head_valid) cur_next = head_data;
            end
        end else if (!cur_valid_reg && head_valid) begin
            cur_valid_next = 1'b1;
            cur_next       = head_data;
            pop            = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        code_reg  <= code_next;
        mod_reg   <= mod_next;
        press_reg <= press_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_event_code     = code_reg;
    assign m_event_modifier = mod_reg;
    assign m_is_press       = press_reg;
    assign m_last_event     = last_reg;

endmodule

// ===== hw/rtl/bkrd_checker.sv =====
module bkrd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_event_code,
    input logic [7:0] m_event_modifier,
    input logic       m_is_press,
    input logic       m_last_event,
    input logic       pready
);

    // stalled event transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_code)
            && $stable(m_is_press) && $stable(m_event_modifier) && $stable(m_last_event))
        else $error("stalled event changed");

    // release events never carry a modifier
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_press |-> m_event_modifier == 8'd0)
        else $error("release event with nonzero modifier");

    // the output is empty right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("event valid after reset");

    // an emitted key code is never zero, since it must exceed min_valid_code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_event_code != 8'd0)
        else $error("event for empty slot");

    assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind boot_keyboard_report_diff bkrd_checker u_bkrd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_event_code     (m_event_code),
    .m_event_modifier (m_event_modifier),
    .m_is_press       (m_is_press),
    .m_last_event     (m_last_event),
    .pready           (pready)
);

// ===== tb/tb_boot_keyboard_report_diff.sv =====
typedef struct {
    bit [7:0] code;
    bit [7:0] modifier;
    bit       press;
    bit       is_last;
} kev_rec_t;

class key_event_board;
    bit [bkrd_pkg::SLOT_COUNT-1:0][7:0] held_keys;
    bit [7:0]                           min_code;
    kev_rec_t                           pending[$];
    int                                 fails;

    function new();
        held_keys = '0;
        min_code  = bkrd_pkg::MIN_VALID_CODE_RESET;
        fails     = 0;
    endfunction

    function bit holds(bit [bkrd_pkg::SLOT_COUNT-1:0][7:0] list, bit [7:0] code);
        for (int i = 0; i < bkrd_pkg::SLOT_COUNT; i++) begin
            if (list[i] == code) return 1'b1;
        end
        return 1'b0;
    endfunction

    // expected events for one accepted report; short reports leave the keys alone
    function void diff_report(bit [6:0] len, bit [7:0] mod,
                              bit [bkrd_pkg::SLOT_COUNT-1:0][7:0] keys);
        kev_rec_t batch[$];
        kev_rec_t ev;
        if (len < bkrd_pkg::BOOT_REPORT_BYTES) return;
        for (int i = 0; i < bkrd_pkg::SLOT_COUNT; i++) begin
            if (held_keys[i] > min_code && !holds(keys, held_keys[i])) begin
                ev.code = held_keys[i];
                ev.modifier = 8'd0;
                ev.press = 1'b0;
                ev.is_last = 1'b0;
                batch.push_back(ev);
            end
            if (keys[i] > min_code && !holds(held_keys, keys[i])) begin
                ev.code = keys[i];
                ev.modifier = mod;
                ev.press = 1'b1;
                ev.is_last = 1'b0;
                batch.push_back(ev);
            end
        end
        if (batch.size() > 0) begin
            ev = batch[batch.size()-1];
            ev.is_last = 1'b1;
            batch[batch.size()-1] = ev;
        end
        foreach (batch[k]) pending.push_back(batch[k]);
        held_keys = keys;
    endfunction

    function void check_event(kev_rec_t got);
        kev_rec_t want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected event code=%0d mod=%0d press=%0d last=%0d",
                     $time, got.code, got.modifier, got.press, got.is_last);
            fails++;
            return;
        end
        want = pending.pop_front();
        if (got.code != want.code) begin
            $display("%0t: event_code expected %0d actual %0d", $time, want.code, got.code);
            fails++;
        end
        if (got.modifier != want.modifier) begin
            $display("%0t: event_modifier expected %0d actual %0d",
                     $time, want.modifier, got.modifier);
            fails++;
        end
        if (got.press != want.press) begin
            $display("%0t: is_press expected %0d actual %0d", $time, want.press, got.press);
            fails++;
        end
        if (got.is_last != want.is_last) begin
            $display("%0t: last_event expected %0d actual %0d",
                     $time, want.is_last, got.is_last);
            fails++;
        end
    endfunction
endclass

module tb_boot_keyboard_report_diff;
    import bkrd_pkg::*;

    localparam logic [2:0] MIN_CODE_ADDR = {REG_MIN_VALID_CODE, 2'b00};
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [6:0]  s_report_len;
    logic [7:0]  s_modifier_bits;
    logic [7:0]  s_key_0, s_key_1, s_key_2, s_key_3, s_key_4, s_key_5;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_event_code;
    logic [7:0]  m_event_modifier;
    logic        m_is_press;
    logic        m_last_event;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    key_event_board board;
    bit             calm;
    bit             hold_req;

    boot_keyboard_report_diff #(.KEY_SLOTS(SLOT_COUNT)) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_report_len     (s_report_len),
        .s_modifier_bits  (s_modifier_bits),
        .s_key_0          (s_key_0),
        .s_key_1          (s_key_1),
        .s_key_2          (s_key_2),
        .s_key_3          (s_key_3),
        .s_key_4          (s_key_4),
        .s_key_5          (s_key_5),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_code     (m_event_code),
        .m_event_modifier (m_event_modifier),
        .m_is_press       (m_is_press),
        .m_last_event     (m_last_event),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("boot_keyboard_report_diff: mismatch");
        $finish;
    end

    function automatic bit [SLOT_COUNT-1:0][7:0] keys6(bit [7:0] k0, bit [7:0] k1,
            bit [7:0] k2, bit [7:0] k3, bit [7:0] k4, bit [7:0] k5);
        return {k5, k4, k3, k2, k1, k0};
    endfunction

    // enters and leaves at a falling edge; valid stays up on return
    task automatic send_report(bit [6:0] len, bit [7:0] mod, bit [SLOT_COUNT-1:0][7:0] keys);
        while (!calm && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_report_len    <= len;
        s_modifier_bits <= mod;
        s_key_0 <= keys[0];
        s_key_1 <= keys[1];
        s_key_2 <= keys[2];
        s_key_3 <= keys[3];
        s_key_4 <= keys[4];
        s_key_5 <= keys[5];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.diff_report(len, mod, keys);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
    endtask

    task automatic read_threshold(bit [7:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= MIN_CODE_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== {24'd0, want}) begin
            $display("%0t: min_valid_code read expected %0d actual %0d", $time, want, prdata);
            board.fails++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_threshold(bit [7:0] value);
        wait_drained();
        // short or no-change reports may still be in flight
        repeat (DRAIN_CYCLES) @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MIN_CODE_ADDR;
        pwdata  <= {24'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        board.min_code = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        read_threshold(value);
    endtask

    // mostly full reports with keys overlapping the previous ones and near the threshold
    task automatic random_phase(int full_reports);
        bit [SLOT_COUNT-1:0][7:0] keys;
        bit [6:0] len;
        int       r, near, done;
        done = 0;
        while (done < full_reports) begin
            if (done == full_reports / 2 && $urandom_range(1) == 1) wait_drained();
            r = $urandom_range(99);
            if (r < 80) len = 7'd8;
            else if (r < 87) len = 7'($urandom_range(64, 9));
            else if (r < 93) len = 7'($urandom_range(127, 65));
            else len = 7'($urandom_range(7));
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r = $urandom_range(99);
                if (r < 35) begin
                    keys[i] = board.held_keys[$urandom_range(SLOT_COUNT-1)];
                end else if (r < 55) begin
                    near = int'(board.min_code) + $urandom_range(7) - 1;
                    if (near < 0) near = 0;
                    if (near > 255) near = 255;
                    keys[i] = 8'(near);
                end else if (r < 68) begin
                    keys[i] = 8'd0;
                end else if (r < 85) begin
                    keys[i] = 8'($urandom_range(20, 4));
                end else begin
                    keys[i] = 8'($urandom_range(255));
                end
            end
            send_report(len, 8'($urandom_range(255)), keys);
            if (len >= BOOT_REPORT_BYTES) done++;
        end
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 20);
            end
        end
    end

    always @(posedge aclk) begin
        kev_rec_t got;
        if (aresetn && m_valid && m_ready) begin
            got.code     = m_event_code;
            got.modifier = m_event_modifier;
            got.press    = m_is_press;
            got.is_last  = m_last_event;
            board.check_event(got);
        end
    end

    initial begin
        board    = new();
        calm     = 1'b0;
        hold_req = 1'b0;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_report_len    = '0;
        s_modifier_bits = '0;
        s_key_0 = '0;
        s_key_1 = '0;
        s_key_2 = '0;
        s_key_3 = '0;
        s_key_4 = '0;
        s_key_5 = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        read_threshold(MIN_VALID_CODE_RESET);

        send_report(7'd8,   8'h00, keys6(0, 0, 0, 0, 0, 0));
        send_report(7'd8,   8'h02, keys6(4, 0, 0, 0, 0, 0));
        // short reports change nothing
        send_report(7'd7,   8'h01, keys6(5, 6, 7, 8, 9, 10));
        send_report(7'd0,   8'hFF, keys6(255, 255, 255, 255, 255, 255));
        send_report(7'd64,  8'hFF, keys6(4, 5, 6, 7, 8, 9));
        send_report(7'd8,   8'h40, keys6(4, 5, 6, 7, 8, 9));
        send_report(7'd127, 8'h11, keys6(10, 11, 12, 13, 14, 15));
        send_report(7'd8,   8'hAA, keys6(255, 255, 3, 2, 1, 0));
        send_report(7'd8,   8'h00, keys6(0, 0, 0, 0, 0, 0));
        send_report(7'd8,   8'h55, keys6(1, 1, 1, 1, 1, 1));
        send_report(7'd8,   8'h01, keys6(3, 4, 3, 4, 0, 5));
        send_report(7'd9,   8'h80, keys6(8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55));
        send_report(7'd8,   8'h7F, keys6(8'h55, 8'hFE, 8'h01, 8'h7F, 8'h80, 8'hFF));
        send_report(7'd65,  8'h00, keys6(0, 0, 0, 0, 0, 0));
        random_phase(40);

        set_threshold(8'd0);
        send_report(7'd8, 8'h03, keys6(0, 1, 2, 3, 0, 1));
        hold_req = 1'b1;
        random_phase(40);

        set_threshold(8'd255);
        send_report(7'd8, 8'hFF, keys6(255, 255, 254, 0, 128, 7));
        random_phase(15);

        set_threshold(8'd10);
        calm = 1'b1;
        random_phase(40);
        calm = 1'b0;

        set_threshold(8'($urandom_range(200, 4)));
        random_phase(35);

        set_threshold(MIN_VALID_CODE_RESET);
        random_phase(30);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (board.pending.size() != 0) begin
            $display("%0t: %0d expected events never arrived", $time, board.pending.size());
            board.fails++;
        end
        if (board.fails == 0) begin
            $display("boot_keyboard_report_diff: match");
        end else begin
            $display("boot_keyboard_report_diff: mismatch");
        end
        $finish;
    end
endmodule
